>>> rtl/assert_macros.svh
// Assertion helpers used by the top-level RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define AAR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check an implication for the next cycle outside reset.
`define AAR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/aarm_pkg.sv
package aarm_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int CW = 34;
  localparam int ZW = 32;
  localparam logic signed [CW-1:0] CORDIC_X0 = 34'sh026DD3B6A;

  typedef struct packed {
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic        [15:0] angle;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } out_item_t;

  typedef struct packed {
    logic               vld;
    logic        [1:0]  quad;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
  } cordic_beat_t;

  function automatic logic signed [ZW-1:0] atan_turn(input int i);
    logic signed [ZW-1:0] t;
    begin
      unique case (i)
        0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
        3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
        6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
        9: t = 32'h00145F2F;  10: t = 32'h000A2F98; 11: t = 32'h000517CC;
        12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
        15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
        18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
        21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
        default: t = '0;
      endcase
      return t;
    end
  endfunction

endpackage

>>> rtl/aarm_cell.sv
module aarm_cell #(
  parameter int STEP = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  aarm_pkg::cordic_beat_t beat_i,
  output aarm_pkg::cordic_beat_t beat_o
);
  import aarm_pkg::*;

  cordic_beat_t beat_r, beat_nxt;
  logic signed [CW-1:0] dx, dy;

  always_comb begin
    dx = beat_i.y >>> STEP;
    dy = beat_i.x >>> STEP;
    beat_nxt = beat_i;
    if (!beat_i.z[ZW-1]) begin
      beat_nxt.x = beat_i.x - dx;
      beat_nxt.y = beat_i.y + dy;
      beat_nxt.z = beat_i.z - atan_turn(STEP);
    end else begin
      beat_nxt.x = beat_i.x + dx;
      beat_nxt.y = beat_i.y - dy;
      beat_nxt.z = beat_i.z + atan_turn(STEP);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r <= '0;
    end else begin
      beat_r <= beat_nxt;
    end
  end

  assign beat_o = beat_r;
endmodule

>>> rtl/aarm_matrix.sv
module aarm_matrix #(
  parameter int FRAC_BITS = 14
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  aarm_pkg::cordic_beat_t beat_i,
  output logic                   out_valid,
  output aarm_pkg::out_item_t    out_item
);
  import aarm_pkg::*;

  localparam int SW = FRAC_BITS + 3;
  localparam int PW = 2 * SW + 2;
  localparam int TW = 3 * SW + 4;
  localparam int RSH = 30 - FRAC_BITS;
  localparam logic signed [SW-1:0] ONE = SW'(1) <<< FRAC_BITS;

  logic signed [CW-1:0] xr, yr;
  logic signed [SW-1:0] cq, sq, c0, s0;

  always_comb begin
    xr = (beat_i.x + (CW'(1) <<< (RSH - 1))) >>> RSH;
    yr = (beat_i.y + (CW'(1) <<< (RSH - 1))) >>> RSH;
    cq = (xr > CW'(ONE)) ? ONE : (xr < -CW'(ONE)) ? -ONE : SW'(xr);
    sq = (yr > CW'(ONE)) ? ONE : (yr < -CW'(ONE)) ? -ONE : SW'(yr);
    unique case (beat_i.quad)
      2'd0: begin c0 = cq;  s0 = sq;  end
      2'd1: begin c0 = -sq; s0 = cq;  end
      2'd2: begin c0 = -cq; s0 = -sq; end
      default: begin c0 = sq; s0 = -cq; end
    endcase
  end

  // stage 1: fold and pair products
  logic vld1_r;
  logic signed [SW-1:0] c1_r, s1_r, omc1_r;
  logic signed [31:0] pxx_r, pyy_r, pzz_r, pxy_r, pxz_r, pyz_r;
  logic signed [15:0] ax1_r, ay1_r, az1_r;

  always_ff @(posedge clk) begin
    c1_r   <= c0;
    s1_r   <= s0;
    omc1_r <= ONE - c0;
    pxx_r  <= beat_i.ax * beat_i.ax;
    pyy_r  <= beat_i.ay * beat_i.ay;
    pzz_r  <= beat_i.az * beat_i.az;
    pxy_r  <= beat_i.ax * beat_i.ay;
    pxz_r  <= beat_i.ax * beat_i.az;
    pyz_r  <= beat_i.ay * beat_i.az;
    ax1_r  <= beat_i.ax;
    ay1_r  <= beat_i.ay;
    az1_r  <= beat_i.az;
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else begin
      vld1_r <= beat_i.vld;
    end
  end

  // stage 2: scale by (1-c) and s
  logic vld2_r;
  logic signed [SW-1:0] c2_r;
  logic signed [TW-1:0] txx_r, tyy_r, tzz_r, txy_r, txz_r, tyz_r;
  logic signed [PW-1:0] sx_r, sy_r, sz_r;

  always_ff @(posedge clk) begin
    c2_r  <= c1_r;
    txx_r <= TW'(pxx_r) * TW'(omc1_r);
    tyy_r <= TW'(pyy_r) * TW'(omc1_r);
    tzz_r <= TW'(pzz_r) * TW'(omc1_r);
    txy_r <= TW'(pxy_r) * TW'(omc1_r);
    txz_r <= TW'(pxz_r) * TW'(omc1_r);
    tyz_r <= TW'(pyz_r) * TW'(omc1_r);
    sx_r  <= PW'(ax1_r) * PW'(s1_r);
    sy_r  <= PW'(ay1_r) * PW'(s1_r);
    sz_r  <= PW'(az1_r) * PW'(s1_r);
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else begin
      vld2_r <= vld1_r;
    end
  end

  function automatic logic signed [TW-1:0] rnd_o(input logic signed [TW-1:0] v);
    return (v + (TW'(1) <<< (2 * FRAC_BITS - 1))) >>> (2 * FRAC_BITS);
  endfunction

  function automatic logic signed [TW-1:0] rnd_s(input logic signed [PW-1:0] v);
    logic signed [TW-1:0] w;
    begin
      w = TW'(v);
      return (w + (TW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    end
  endfunction

  function automatic logic signed [15:0] sat(input logic signed [TW-1:0] v);
    if (v > TW'(32767)) return 16'sh7FFF;
    if (v < -TW'(32768)) return 16'sh8000;
    return v[15:0];
  endfunction

  logic signed [TW-1:0] oxy, oxz, oyz, cw, rx, ry, rz;
  out_item_t res;

  always_comb begin
    oxy = rnd_o(txy_r);
    oxz = rnd_o(txz_r);
    oyz = rnd_o(tyz_r);
    cw  = TW'(c2_r);
    rx  = rnd_s(sx_r);
    ry  = rnd_s(sy_r);
    rz  = rnd_s(sz_r);
    res.m00 = sat(cw + rnd_o(txx_r));
    res.m01 = sat(oxy - rz);
    res.m02 = sat(oxz + ry);
    res.m10 = sat(oxy + rz);
    res.m11 = sat(cw + rnd_o(tyy_r));
    res.m12 = sat(oyz - rx);
    res.m20 = sat(oxz - ry);
    res.m21 = sat(oyz + rx);
    res.m22 = sat(cw + rnd_o(tzz_r));
  end

  logic out_valid_r;
  out_item_t out_item_r;

  always_ff @(posedge clk) begin
    out_item_r <= res;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld2_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
endmodule

>>> rtl/axis_angle_rotation_matrix.sv
// Throughput: one item per cycle; busy stays low, the pipeline never stalls.
// 24 CORDIC cells set the depth, plus a fold/product stage, a scale stage
// and the output register.
// Reset (synchronous, rst_n low) clears all valid flags and the CORDIC cells;
// product and output data are not cleared.
module axis_angle_rotation_matrix #(
  parameter int ANGLE_BITS = 16,
  parameter int FRAC_BITS  = 14
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  aarm_pkg::in_item_t  in_item,
  output logic                out_valid,
  output aarm_pkg::out_item_t out_item
);
  import aarm_pkg::*;
  `include "assert_macros.svh"

  logic [31:0] phase;
  cordic_beat_t chain [CORDIC_STEPS+1];

  always_comb begin
    phase = 32'({16'd0, in_item.angle} << (32 - ANGLE_BITS));
    chain[0].vld  = start & ~busy;
    chain[0].quad = phase[31:30];
    chain[0].x    = CORDIC_X0;
    chain[0].y    = '0;
    chain[0].z    = ZW'({2'b00, phase[29:0]});
    chain[0].ax   = in_item.axis_x;
    chain[0].ay   = in_item.axis_y;
    chain[0].az   = in_item.axis_z;
  end

  assign busy = 1'b0;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    aarm_cell #(.STEP(i)) u_cell (
      .clk(clk), .rst_n(rst_n), .beat_i(chain[i]), .beat_o(chain[i+1])
    );
  end

  aarm_matrix #(.FRAC_BITS(FRAC_BITS)) u_matrix (
    .clk(clk), .rst_n(rst_n), .beat_i(chain[CORDIC_STEPS]),
    .out_valid(out_valid), .out_item(out_item)
  );

  `AAR_ASSERT_NEXT(a_lat_first, clk, rst_n, start, chain[1].vld, "beat lost at first cell")
  `AAR_ASSERT_IMP(a_lat_out, clk, rst_n, $past(chain[CORDIC_STEPS].vld, 3), out_valid,
    "beat lost in product stages")
  `AAR_ASSERT_IMP(a_no_ghost, clk, rst_n, out_valid, $past(chain[CORDIC_STEPS].vld, 3),
    "result without beat")
endmodule

>>> sim/tb.sv
module tb;
  import aarm_pkg::*;

  localparam int NUM_RANDOM = 1150;
  localparam int LATENCY = 28;
  localparam longint CYCLE_LIMIT = 200000;
  localparam int ONE = 1 << 14;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_item = '0;
  logic out_valid;
  out_item_t out_item;

  out_item_t matrix_q[$];
  bit has_fixed_q[$];
  out_item_t fixed_q[$];
  int errors = 0;
  longint cycles = 0;

  axis_angle_rotation_matrix u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  always #1 clk = ~clk;

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_by(longint v, int s);
    return floor_shift(v + (longint'(1) << (s - 1)), s);
  endfunction

  function automatic longint clamp_unit(longint v);
    longint r;
    r = round_by(v, 16);
    if (r > ONE) r = ONE;
    if (r < -ONE) r = -ONE;
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic out_item_t rotation_matrix(in_item_t it);
    longint tbl[24] = '{
      'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
      'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
      'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
      'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051};
    longint x, y, z, dx, dy, c0, s0, c, s, omc, ax, ay, az, oxy, oxz, oyz;
    logic [31:0] phase;
    out_item_t m;
    phase = {it.angle, 16'h0};
    z = longint'(phase[29:0]);
    x = 'h26DD3B6A;
    y = 0;
    for (int i = 0; i < 24; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= tbl[i];
      end else begin
        x += dx; y -= dy; z += tbl[i];
      end
    end
    c0 = clamp_unit(x);
    s0 = clamp_unit(y);
    case (phase[31:30])
      2'd0: begin c = c0;  s = s0;  end
      2'd1: begin c = -s0; s = c0;  end
      2'd2: begin c = -c0; s = -s0; end
      default: begin c = s0; s = -c0; end
    endcase
    ax = it.axis_x; ay = it.axis_y; az = it.axis_z;
    omc = ONE - c;
    oxy = round_by(ax * ay * omc, 28);
    oxz = round_by(ax * az * omc, 28);
    oyz = round_by(ay * az * omc, 28);
    m.m00 = sat16(c + round_by(ax * ax * omc, 28));
    m.m01 = sat16(oxy - round_by(az * s, 14));
    m.m02 = sat16(oxz + round_by(ay * s, 14));
    m.m10 = sat16(oxy + round_by(az * s, 14));
    m.m11 = sat16(c + round_by(ay * ay * omc, 28));
    m.m12 = sat16(oyz - round_by(ax * s, 14));
    m.m20 = sat16(oxz - round_by(ay * s, 14));
    m.m21 = sat16(oyz + round_by(ax * s, 14));
    m.m22 = sat16(c + round_by(az * az * omc, 28));
    return m;
  endfunction

  task automatic compare_field(string name, logic signed [15:0] exp_v,
                               logic signed [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (start && !busy && rst_n) begin
      matrix_q.push_back(rotation_matrix(in_item));
    end
    if (out_valid && rst_n) begin
      if (matrix_q.size() == 0) begin
        $error("out_item: unexpected beat");
        errors++;
      end else begin
        out_item_t e;
        bit fx;
        out_item_t f;
        e = matrix_q.pop_front();
        fx = has_fixed_q.pop_front();
        f = fixed_q.pop_front();
        if (fx && f !== e) begin
          $error("typed row: expected %h, predictor %h", f, e);
          errors++;
        end
        compare_field("m00", e.m00, out_item.m00);
        compare_field("m01", e.m01, out_item.m01);
        compare_field("m02", e.m02, out_item.m02);
        compare_field("m10", e.m10, out_item.m10);
        compare_field("m11", e.m11, out_item.m11);
        compare_field("m12", e.m12, out_item.m12);
        compare_field("m20", e.m20, out_item.m20);
        compare_field("m21", e.m21, out_item.m21);
        compare_field("m22", e.m22, out_item.m22);
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  typedef struct {
    in_item_t item;
    bit       typed;
    out_item_t result;
  } vector_t;

  localparam out_item_t IDENT = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384,
                                 16'sd0, 16'sd0, 16'sd0, 16'sd16384};
  localparam out_item_t HALF_Z = '{-16'sd16384, 16'sd0, 16'sd0, 16'sd0, -16'sd16384,
                                  16'sd0, 16'sd0, 16'sd0, 16'sd16384};

  vector_t vectors[] = '{
    '{'{16'sd0, 16'sd0, 16'sd16384, 16'd0}, 1'b1, IDENT},
    '{'{16'sd0, 16'sd0, 16'sd16384, 16'd32768}, 1'b1, HALF_Z},
    '{'{16'sd0, 16'sd0, 16'sd0, 16'd0}, 1'b0, '0},
    '{'{16'sd16384, 16'sd0, 16'sd0, 16'd16384}, 1'b0, '0},
    '{'{16'sd0, 16'sd16384, 16'sd0, 16'd49152}, 1'b0, '0},
    '{'{-16'sd16384, 16'sd0, 16'sd0, 16'd65535}, 1'b0, '0},
    '{'{16'sd0, -16'sd16384, 16'sd0, 16'd1}, 1'b0, '0},
    '{'{16'sd0, 16'sd0, -16'sd16384, 16'd8192}, 1'b0, '0},
    '{'{16'sd9459, 16'sd9459, 16'sd9459, 16'd21845}, 1'b0, '0},
    '{'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'd32768}, 1'b0, '0},
    '{'{-16'sh8000, -16'sh8000, -16'sh8000, 16'd32768}, 1'b0, '0},
    '{'{16'sh7FFF, -16'sh8000, 16'sh7FFF, 16'd16384}, 1'b0, '0},
    '{'{-16'sh8000, 16'sh7FFF, 16'sd0, 16'd40000}, 1'b0, '0},
    '{'{16'shFFFF, 16'sh5555, 16'shAAAA, 16'd12345}, 1'b0, '0},
    '{'{16'sd11585, 16'sd11585, 16'sd0, 16'd57344}, 1'b0, '0}
  };

  task automatic send_beat(in_item_t it, bit typed, out_item_t res);
    in_item <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    has_fixed_q.push_back(typed);
    fixed_q.push_back(res);
    @(negedge clk);
  endtask

  task automatic idle(int n);
    start <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(0, 9))
      0: return 16'(int'($urandom()));
      1: return 16'sd16384;
      2: return -16'sd16384;
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    real nx, ny, nz, len;
    it.angle = 16'($urandom());
    if ($urandom_range(0, 3) != 0) begin
      nx = real'($signed($urandom_range(0, 2000)) - 1000);
      ny = real'($signed($urandom_range(0, 2000)) - 1000);
      nz = real'($signed($urandom_range(0, 2000)) - 1000);
      len = $sqrt(nx * nx + ny * ny + nz * nz);
      if (len < 1.0) begin
        nz = 1.0; len = 1.0;
      end
      it.axis_x = 16'($rtoi(nx / len * 16384.0));
      it.axis_y = 16'($rtoi(ny / len * 16384.0));
      it.axis_z = 16'($rtoi(nz / len * 16384.0));
    end else begin
      it.axis_x = rand_comp();
      it.axis_y = rand_comp();
      it.axis_z = rand_comp();
    end
    return it;
  endfunction

  initial begin
    int sent;
    int burst;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (vectors[i]) send_beat(vectors[i].item, vectors[i].typed, vectors[i].result);
    idle(3);
    sent = 0;
    while (sent < NUM_RANDOM) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && sent < NUM_RANDOM; k++) begin
        send_beat(rand_item(), 1'b0, '0);
        sent++;
      end
      if (sent > NUM_RANDOM / 2 && sent - burst <= NUM_RANDOM / 2) begin
        start <= 1'b0;
        while (matrix_q.size() != 0) @(negedge clk);
      end
      if ($urandom_range(0, 2) != 0) idle($urandom_range(1, 35));
    end
    start <= 1'b0;
    while (matrix_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
    if (errors == 0 && matrix_q.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule
